>>> hdl/q2e_pkg.sv
`timescale 1ns / 1ps
package q2e_pkg;

    // atan(2^-i) with pi = 2^31
    localparam int AtanLen = 24;
    localparam logic [31:0] ATAN_STEPS [AtanLen] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81
    };

    // pole limit on t = xz - wy in q30
    localparam logic signed [33:0] POLE_LIMIT = 34'sd536869838;

    typedef enum logic [1:0] {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2
    } pole_t;

    // per-stage sideband that rides with the data
    typedef struct packed {
        logic  vld;
        pole_t pole;
    } q2e_ctl_t;

endpackage

>>> hdl/q2e_cordic_stage.sv
`timescale 1ns / 1ps
// one vectoring cordic micro-rotation with output register and stall hold
module q2e_cordic_stage
    import q2e_pkg::*;
#(
    parameter int DW    = 36,
    parameter int AW    = 16,
    parameter int STAGE = 0
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [DW-1:0] x_in,
    input  logic signed [DW-1:0] y_in,
    input  logic signed [AW-1:0] z_in,
    output logic signed [DW-1:0] x_out,
    output logic signed [DW-1:0] y_out,
    output logic signed [AW-1:0] z_out
);

    localparam int           Sh   = 32 - AW;
    localparam logic [32:0]  Rnd  = (Sh == 0) ? 33'd0 : (33'd1 << (Sh - 1));
    localparam logic [32:0]  Sum  = {1'b0, ATAN_STEPS[STAGE % AtanLen]} + Rnd;
    localparam logic [32:0]  Step = Sum >> Sh;

    logic signed [DW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [AW-1:0] z_reg, z_next;
    logic signed [DW-1:0] dx, dy;

    // rotate toward the x axis
    always_comb begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (y_in > 0) begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + Step[AW-1:0];
        end else begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - Step[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

>>> hdl/q2e_isqrt.sv
`timescale 1ns / 1ps
// pipelined restoring square root of a 62-bit value, two result bits per stage (one in the last)
module q2e_isqrt
    import q2e_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [61:0] rad_in,
    output logic [30:0] root_out
);

    localparam int Bits  = 31;
    localparam int Steps = 16;

    logic [61:0] rem_reg  [Steps];
    logic [61:0] rad_reg  [Steps];
    logic [30:0] root_reg [Steps];

    // bit-by-bit digit recurrence, two digits per register (one in the last)
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < Steps; s++) begin
                logic [61:0] rm, rd;
                logic [30:0] rt;
                logic [63:0] trial;
                if (s == 0) begin
                    rm = '0;
                    rd = rad_in;
                    rt = '0;
                end else begin
                    rm = rem_reg[s-1];
                    rd = rad_reg[s-1];
                    rt = root_reg[s-1];
                end
                for (int k = 0; k < 2; k++) begin
                    if (2 * s + k < Bits) begin
                        rm = {rm[59:0], rd[61:60]};
                        rd = {rd[59:0], 2'b00};
                        trial = 64'({rt, 2'b01});
                        if ({2'b00, rm} >= trial) begin
                            rm = rm - trial[61:0];
                            rt = {rt[29:0], 1'b1};
                        end else begin
                            rt = {rt[29:0], 1'b0};
                        end
                    end
                end
                rem_reg[s]  <= rm;
                rad_reg[s]  <= rd;
                root_reg[s] <= rt;
            end
        end
    end

    assign root_out = root_reg[Steps-1];

endmodule

>>> hdl/q2e_atan2.sv
`timescale 1ns / 1ps
// atan2 by vectoring cordic: quadrant fold, cordic stages, rounding or scaling to 16 bits
module q2e_atan2
    import q2e_pkg::*;
#(
    parameter int DW     = 36,
    parameter int AW     = 16,
    parameter int STAGES = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [DW-1:0] y_in,
    input  logic signed [DW-1:0] x_in,
    output logic signed [15:0]   angle_out
);

    localparam int NSt = (STAGES < AtanLen) ? STAGES : AtanLen;
    localparam int ZW  = (AW > 16) ? AW + 1 : 17;

    logic signed [DW-1:0] xs [NSt+1];
    logic signed [DW-1:0] ys [NSt+1];
    logic signed [AW-1:0] zs [NSt+1];
    logic                 zero_pipe_reg [NSt+1];
    logic signed [DW-1:0] fx_reg, fy_reg;
    logic signed [AW-1:0] fz_reg;
    logic signed [15:0]   ang_reg;
    logic signed [ZW-1:0] zr;

    localparam logic signed [AW-1:0] HalfPi = AW'(1) <<< (AW - 2);

    // quadrant fold into the right half plane
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_pipe_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0 && y_in >= 0) begin
                fx_reg <= y_in;
                fy_reg <= -x_in;
                fz_reg <= HalfPi;
            end else if (x_in < 0) begin
                fx_reg <= -y_in;
                fy_reg <= x_in;
                fz_reg <= -HalfPi;
            end else begin
                fx_reg <= x_in;
                fy_reg <= y_in;
                fz_reg <= '0;
            end
        end
    end

    assign xs[0] = fx_reg;
    assign ys[0] = fy_reg;
    assign zs[0] = fz_reg;

    for (genvar g = 0; g < NSt; g++) begin : g_st
        q2e_cordic_stage #(.DW(DW), .AW(AW), .STAGE(g)) u_st (
            .aclk  (aclk),
            .en    (en),
            .x_in  (xs[g]),
            .y_in  (ys[g]),
            .z_in  (zs[g]),
            .x_out (xs[g+1]),
            .y_out (ys[g+1]),
            .z_out (zs[g+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                zero_pipe_reg[g+1] <= zero_pipe_reg[g];
            end
        end
    end

    // round half up to 16 bits or scale up
    if (AW > 16) begin : g_rnd
        always_comb begin
            zr = (ZW'(zs[NSt]) + (ZW'(1) <<< (AW - 17))) >>> (AW - 16);
        end
    end else begin : g_scl
        always_comb begin
            zr = ZW'(zs[NSt]) <<< (16 - AW);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= zero_pipe_reg[NSt] ? 16'sd0 : zr[15:0];
        end
    end

    assign angle_out = ang_reg;

endmodule

>>> hdl/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// the pitch path runs through the product stages, a 16-stage square root and the cordic stages
// throughput: one request per cycle; a stalled output freezes the whole pipeline
// reset: aresetn clears the valid bits only; no state is kept between requests
module quaternion_to_euler_angles
    import q2e_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int ANGLE_WIDTH   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // yaw_angle[15:0], pitch_angle[31:16], roll_angle[47:32]
    output logic [47:0] m_tdata,
    // pole_flag[1:0]
    output logic [1:0]  m_tuser
);

    localparam int DW   = 36;
    localparam int NSt  = (CORDIC_STAGES < AtanLen) ? CORDIC_STAGES : AtanLen;
    localparam int SqL  = 16;
    localparam int CorL = NSt + 2;
    localparam int Lat  = 3 + SqL + CorL;

    logic en;
    logic vld_reg [Lat];

    assign en       = ~vld_reg[Lat-1] | m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[Lat-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < Lat; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < Lat; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // stage 1: products in q30
    logic signed [15:0] qw, qx, qy, qz;
    assign qw = s_tdata[15:0];
    assign qx = s_tdata[31:16];
    assign qy = s_tdata[47:32];
    assign qz = s_tdata[63:48];

    logic signed [31:0] ww_reg, xx_reg, zz_reg, xy_reg, wz_reg, yz_reg, wx_reg,
                        xz_reg, wy_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ww_reg <= qw * qw;  xx_reg <= qx * qx;  zz_reg <= qz * qz;
            xy_reg <= qx * qy;  wz_reg <= qw * qz;  yz_reg <= qy * qz;
            wx_reg <= qw * qx;  xz_reg <= qx * qz;  wy_reg <= qw * qy;
        end
    end

    // stage 2: atan arguments, pole test, s
    localparam logic signed [DW-1:0] One = DW'(1) <<< 30;
    logic signed [DW-1:0] yy_reg, yx_reg, ry_reg, rx_reg;
    logic signed [33:0]   t_c;
    logic [31:0]          mag_reg;
    logic signed [DW-1:0] s_reg;
    pole_t                pole_reg;
    assign t_c = 34'(xz_reg) - 34'(wy_reg);
    always_ff @(posedge aclk) begin
        if (en) begin
            yy_reg <= (DW'(xy_reg) <<< 1) + (DW'(wz_reg) <<< 1);
            yx_reg <= (DW'(ww_reg) <<< 1) + (DW'(xx_reg) <<< 1) - One;
            ry_reg <= (DW'(yz_reg) <<< 1) + (DW'(wx_reg) <<< 1);
            rx_reg <= (DW'(ww_reg) <<< 1) + (DW'(zz_reg) <<< 1) - One;
            s_reg  <= DW'(t_c) <<< 1;
            mag_reg <= t_c[33] ? 32'(-(t_c <<< 1)) : 32'(t_c <<< 1);
            if (t_c > POLE_LIMIT)       pole_reg <= POLE_NORTH;
            else if (t_c < -POLE_LIMIT) pole_reg <= POLE_SOUTH;
            else                        pole_reg <= POLE_NONE;
        end
    end

    // stage 3: radicand 2^60 - s^2 (s bounded below 2^30 when not at a pole)
    logic [61:0] rad_reg;
    logic [63:0] sq;
    assign sq = mag_reg * mag_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg <= 62'((64'd1 << 60) - sq);
        end
    end

    // delay lines to align yaw, roll and s with the square root, and the pole flag with the output
    logic signed [DW-1:0] yy_d [SqL+1], yx_d [SqL+1], ry_d [SqL+1], rx_d [SqL+1];
    logic signed [DW-1:0] s_d  [SqL+1];
    pole_t                pole_d [Lat];
    always_ff @(posedge aclk) begin
        if (en) begin
            yy_d[0] <= yy_reg; yx_d[0] <= yx_reg;
            ry_d[0] <= ry_reg; rx_d[0] <= rx_reg;
            s_d[0]  <= s_reg;
            for (int i = 1; i <= SqL; i++) begin
                yy_d[i] <= yy_d[i-1]; yx_d[i] <= yx_d[i-1];
                ry_d[i] <= ry_d[i-1]; rx_d[i] <= rx_d[i-1];
                s_d[i]  <= s_d[i-1];
            end
            pole_d[2] <= pole_reg;
            for (int i = 3; i < Lat; i++) pole_d[i] <= pole_d[i-1];
        end
    end

    logic [30:0] root;
    q2e_isqrt u_sqrt (.aclk(aclk), .en(en), .rad_in(rad_reg), .root_out(root));

    // cordic units: yaw, pitch, roll
    logic signed [15:0] yaw_a, pitch_a, roll_a;
    q2e_atan2 #(.DW(DW), .AW(ANGLE_WIDTH), .STAGES(CORDIC_STAGES)) u_yaw (
        .aclk(aclk), .en(en), .y_in(yy_d[SqL]), .x_in(yx_d[SqL]),
        .angle_out(yaw_a));
    q2e_atan2 #(.DW(DW), .AW(ANGLE_WIDTH), .STAGES(CORDIC_STAGES)) u_pitch (
        .aclk(aclk), .en(en), .y_in(-s_d[SqL]), .x_in(DW'(root)),
        .angle_out(pitch_a));
    q2e_atan2 #(.DW(DW), .AW(ANGLE_WIDTH), .STAGES(CORDIC_STAGES)) u_roll (
        .aclk(aclk), .en(en), .y_in(ry_d[SqL]), .x_in(rx_d[SqL]),
        .angle_out(roll_a));

    // output select: clamp pitch, pole override
    pole_t              pole_o;
    logic signed [15:0] pitch_o, roll_o;
    assign pole_o = pole_d[Lat-1];
    always_comb begin
        unique case (pole_o)
            POLE_NORTH: begin pitch_o = -16'sd16384; roll_o = '0; end
            POLE_SOUTH: begin pitch_o = 16'sd16384;  roll_o = '0; end
            default: begin
                roll_o = roll_a;
                if (pitch_a > 16'sd16384)       pitch_o = 16'sd16384;
                else if (pitch_a < -16'sd16384) pitch_o = -16'sd16384;
                else                            pitch_o = pitch_a;
            end
        endcase
    end

    assign m_tdata = {roll_o, pitch_o, yaw_a};
    assign m_tuser = pole_o;

endmodule
